// ===== src/assert_macros.svh =====
// Assertion shorthands shared by the encoder modules.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the following cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/smte_pkg.sv =====
// ----------------------------------------------------------------------------
// smte_pkg
// Shared types and constants of the track event encoder: event codes,
// MIDI status and meta bytes, item and command layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package smte_pkg;

    localparam int unsigned TICK_W      = 28;
    localparam int unsigned BODY_MAX    = 7;
    localparam int unsigned BODY_IDX_W  = 3;
    localparam int unsigned QUEUE_DEPTH = 4;

    // Event codes
    typedef enum logic [2:0] {
        OP_NOTE_OFF  = 3'd0,
        OP_NOTE_ON   = 3'd1,
        OP_PROGRAM   = 3'd2,
        OP_TEMPO     = 3'd3,
        OP_TIME_SIG  = 3'd4,
        OP_KEY_SIG   = 3'd5,
        OP_END_TRACK = 3'd6
    } t_opcode;

    // Channel status bytes
    localparam logic [7:0] ST_NOTE_OFF = 8'h80;
    localparam logic [7:0] ST_NOTE_ON  = 8'h90;
    localparam logic [7:0] ST_PROGRAM  = 8'hC0;

    // Meta event bytes
    localparam logic [7:0] META_PREFIX   = 8'hFF;
    localparam logic [7:0] META_TEMPO    = 8'h51;
    localparam logic [7:0] META_TIME_SIG = 8'h58;
    localparam logic [7:0] META_KEY_SIG  = 8'h59;
    localparam logic [7:0] META_END      = 8'h2F;
    localparam logic [7:0] LEN_TEMPO     = 8'h03;
    localparam logic [7:0] LEN_TIME_SIG  = 8'h04;
    localparam logic [7:0] LEN_KEY_SIG   = 8'h02;
    localparam logic [7:0] LEN_END       = 8'h00;
    localparam logic [7:0] CLOCKS_PER_CLICK  = 8'd24;
    localparam logic [7:0] N32_PER_QUARTER   = 8'd8;

    // Key signature clamp limits
    localparam logic signed [7:0] FIFTHS_MIN = -8'sd7;
    localparam logic signed [7:0] FIFTHS_MAX = 8'sd7;

    // Input beat
    typedef struct packed {
        logic [2:0]        opcode;
        logic [27:0]       tick;
        logic [6:0]        pitch;
        logic [6:0]        velocity;
        logic [6:0]        program_req;
        logic [23:0]       tempo_us;
        logic [7:0]        sig_numerator;
        logic [6:0]        sig_denominator;
        logic signed [7:0] key_fifths;
        logic              key_minor;
    } t_in_item;

    // Result beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_out_item;

    // Classified event handed from front to back: delta plus body bytes
    typedef struct packed {
        logic [TICK_W-1:0]            delta;
        logic [BODY_MAX-1:0][7:0]     body;
        logic [BODY_IDX_W-1:0]        body_len;
    } t_cmd;

endpackage

`default_nettype wire

// ===== src/smte_front.sv =====
// ----------------------------------------------------------------------------
// smte_front
// Accepts track events, computes the saturated delta time, builds the event
// body bytes and holds one classified command for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module smte_front
    import smte_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [3:0] i_cfg_wdata,
    input  wire logic       i_push,
    input  wire t_in_item   i_item,
    output logic            o_full,
    output logic            o_q_push,
    output t_cmd            o_q_cmd,
    input  wire logic       i_q_full
);

    logic [3:0]          r_channel;
    logic [TICK_W-1:0]   r_prev_tick;
    logic                r_valid;
    t_cmd                r_cmd;

    logic                w_accept;
    logic                w_op_ok;
    logic                w_load;
    logic [TICK_W:0]     w_diff;
    logic [TICK_W-1:0]   w_delta;
    logic [BODY_MAX-1:0][7:0] n_body;
    logic [BODY_IDX_W-1:0]    n_len;
    logic [7:0]          w_denom_pow;
    logic [7:0]          w_fifths;

    // Handshake: the holding register frees when the queue takes its beat
    assign w_load   = !r_valid || !i_q_full;
    assign o_full   = r_valid && i_q_full;
    assign w_accept = i_push && !o_full;
    assign w_op_ok  = i_item.opcode <= OP_END_TRACK;
    assign o_q_push = r_valid && !i_q_full;
    assign o_q_cmd  = r_cmd;

    // Delta from the previous event, zero when time runs backwards
    assign w_diff  = {1'b0, i_item.tick} - {1'b0, r_prev_tick};
    assign w_delta = w_diff[TICK_W] ? '0 : w_diff[TICK_W-1:0];

    // Map denominator to its power of two
    always_comb begin
        unique case (i_item.sig_denominator)
            7'd1:    w_denom_pow = 8'd0;
            7'd2:    w_denom_pow = 8'd1;
            7'd4:    w_denom_pow = 8'd2;
            7'd8:    w_denom_pow = 8'd3;
            7'd16:   w_denom_pow = 8'd4;
            7'd32:   w_denom_pow = 8'd5;
            7'd64:   w_denom_pow = 8'd6;
            default: w_denom_pow = 8'd2;
        endcase
    end

    // Clamp fifths to a legal key
    always_comb begin
        if (i_item.key_fifths < FIFTHS_MIN) begin
            w_fifths = FIFTHS_MIN;
        end else if (i_item.key_fifths > FIFTHS_MAX) begin
            w_fifths = FIFTHS_MAX;
        end else begin
            w_fifths = i_item.key_fifths;
        end
    end

    // Build the event body
    always_comb begin
        n_body = '0;
        n_len  = BODY_IDX_W'(3);
        unique case (i_item.opcode)
            OP_NOTE_OFF: begin
                n_body[0] = ST_NOTE_OFF | {4'h0, r_channel};
                n_body[1] = {1'b0, i_item.pitch};
                n_body[2] = 8'h00;
            end
            OP_NOTE_ON: begin
                n_body[0] = ST_NOTE_ON | {4'h0, r_channel};
                n_body[1] = {1'b0, i_item.pitch};
                n_body[2] = {1'b0, i_item.velocity};
            end
            OP_PROGRAM: begin
                n_body[0] = ST_PROGRAM | {4'h0, r_channel};
                n_body[1] = {1'b0, i_item.program_req};
                n_len     = BODY_IDX_W'(2);
            end
            OP_TEMPO: begin
                n_body[0] = META_PREFIX;
                n_body[1] = META_TEMPO;
                n_body[2] = LEN_TEMPO;
                n_body[3] = i_item.tempo_us[23:16];
                n_body[4] = i_item.tempo_us[15:8];
                n_body[5] = i_item.tempo_us[7:0];
                n_len     = BODY_IDX_W'(6);
            end
            OP_TIME_SIG: begin
                n_body[0] = META_PREFIX;
                n_body[1] = META_TIME_SIG;
                n_body[2] = LEN_TIME_SIG;
                n_body[3] = i_item.sig_numerator;
                n_body[4] = w_denom_pow;
                n_body[5] = CLOCKS_PER_CLICK;
                n_body[6] = N32_PER_QUARTER;
                n_len     = BODY_IDX_W'(7);
            end
            OP_KEY_SIG: begin
                n_body[0] = META_PREFIX;
                n_body[1] = META_KEY_SIG;
                n_body[2] = LEN_KEY_SIG;
                n_body[3] = w_fifths;
                n_body[4] = {7'h00, i_item.key_minor};
                n_len     = BODY_IDX_W'(5);
            end
            default: begin
                n_body[0] = META_PREFIX;
                n_body[1] = META_END;
                n_body[2] = LEN_END;
            end
        endcase
    end

    // Hold channel, previous tick and the command valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel   <= '0;
            r_prev_tick <= '0;
            r_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_channel <= i_cfg_wdata;
            end
            if (w_load) begin
                r_valid <= w_accept && w_op_ok;
            end
            if (w_accept && w_op_ok) begin
                r_prev_tick <= (i_item.opcode == OP_END_TRACK) ? '0 : i_item.tick;
            end
        end
    end

    // Capture the classified command
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd.delta    <= w_delta;
            r_cmd.body     <= n_body;
            r_cmd.body_len <= n_len;
        end
    end

endmodule

`default_nettype wire

// ===== src/smte_queue.sv =====
// ----------------------------------------------------------------------------
// smte_queue
// Short command queue between the classifying front and the byte emitter.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module smte_queue
    import smte_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output logic      o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Store commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    `ASSERT_IMPLIES(a_no_overflow, i_push, !o_full || i_pop, "queue push while full")
    `ASSERT_IMPLIES(a_no_underflow, i_pop, !o_empty, "queue pop while empty")
    `ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(DEPTH), "queue count past depth")

endmodule

`default_nettype wire

// ===== src/smte_back.sv =====
// ----------------------------------------------------------------------------
// smte_back
// Emits one track byte per cycle, stalling while the output register holds an
// unpopped byte: the delta as a variable-length quantity, then the body bytes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module smte_back
    import smte_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_head,
    input  wire logic i_q_empty,
    output logic      o_q_pop,
    output t_out_item o_result,
    output logic      o_empty,
    input  wire logic i_pop
);

    t_cmd                  r_cmd;
    logic                  r_active;
    logic                  r_in_delta;
    logic [1:0]            r_grp;
    logic [BODY_IDX_W-1:0] r_bidx;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic                  w_step;
    logic                  w_cur_last;
    logic                  w_load;
    logic [7:0]            w_byte;
    logic [1:0]            w_head_grp;

    assign w_step     = r_active && (!r_out_valid || i_pop);
    assign w_cur_last = !r_in_delta && (r_bidx == r_cmd.body_len - 1'b1);
    assign w_load     = (!r_active || (w_step && w_cur_last)) && !i_q_empty;
    assign o_q_pop    = w_load;
    assign o_result   = r_out;
    assign o_empty    = !r_out_valid;

    // Number of delta groups beyond the first
    always_comb begin
        if (i_head.delta[27:21] != '0) begin
            w_head_grp = 2'd3;
        end else if (i_head.delta[20:14] != '0) begin
            w_head_grp = 2'd2;
        end else if (i_head.delta[13:7] != '0) begin
            w_head_grp = 2'd1;
        end else begin
            w_head_grp = 2'd0;
        end
    end

    // Select the current byte
    always_comb begin
        if (r_in_delta) begin
            case (r_grp)
                2'd3:    w_byte = {1'b1, r_cmd.delta[27:21]};
                2'd2:    w_byte = {1'b1, r_cmd.delta[20:14]};
                2'd1:    w_byte = {1'b1, r_cmd.delta[13:7]};
                default: w_byte = {1'b0, r_cmd.delta[6:0]};
            endcase
        end else begin
            w_byte = r_cmd.body[r_bidx];
        end
    end

    // Sequence delta groups and body bytes; hold the output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_in_delta  <= 1'b0;
            r_grp       <= '0;
            r_bidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_active   <= 1'b1;
                r_in_delta <= 1'b1;
                r_grp      <= w_head_grp;
                r_bidx     <= '0;
            end else if (w_step) begin
                if (w_cur_last) begin
                    r_active <= 1'b0;
                end
                if (r_in_delta) begin
                    if (r_grp == 2'd0) begin
                        r_in_delta <= 1'b0;
                    end else begin
                        r_grp <= r_grp - 1'b1;
                    end
                end else begin
                    r_bidx <= r_bidx + 1'b1;
                end
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture command and output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cmd <= i_head;
        end
        if (w_step) begin
            r_out.out_byte  <= w_byte;
            r_out.last_byte <= w_cur_last;
        end
    end

    `ASSERT_NEXT(a_cont_bit, w_step && r_in_delta && (r_grp != 2'd0), r_out.out_byte[7],
        "delta group lost its continuation bit")
    `ASSERT_NEXT(a_delta_not_last, w_step && r_in_delta, !r_out.last_byte,
        "delta byte flagged as last")
    `ASSERT_IMPLIES(a_load_when_free, w_load, !r_active || w_cur_last,
        "command loaded over an unfinished one")

endmodule

`default_nettype wire

// ===== src/midi_track_event_encoder.sv =====
// ----------------------------------------------------------------------------
// midi_track_event_encoder
// Turns time-ordered track events into Standard MIDI File track bytes:
// variable-length delta time followed by the event body.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  input     in         push / full         i_item   (t_in_item)
//  result    out        pop / empty         o_result (t_out_item), one byte
//  config    in         i_cfg_we            i_cfg_wdata (channel)
//
//  The emitter sends one byte per cycle unless pop is low; an event is 1 to 4
//  delta bytes plus 2 to 7 body bytes.
//  The front takes an event per cycle while the command queue has room;
//  FIFO_DEPTH commands plus one holding register buffer the two sides.
//  Reset is synchronous and needs no clearing pass; opcode 7 is dropped.
//  Pop low holds the current result byte; the emitter then stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_track_event_encoder
    import smte_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [3:0] i_cfg_wdata,
    input  wire logic       push,
    input  wire t_in_item   i_item,
    output logic            full,
    input  wire logic       pop,
    output logic            empty,
    output t_out_item       o_result
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_cmd q_cmd;
    t_cmd q_head;

    smte_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_cmd),
        .i_q_full    (q_full)
    );

    smte_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    smte_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (q_head),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_result  (o_result),
        .o_empty   (empty),
        .i_pop     (pop)
    );

endmodule

`default_nettype wire
